### src/assert_macros.svh
// Assertion macros shared by the framebuffer engine RTL.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define AM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define AM_FORBID(lbl, clk, rst, cond, msg) \
   `AM_ASSERT(lbl, clk, rst, !(cond), msg)

`endif

### src/ofb_pkg.sv
// Shared types and constants for the monochrome OLED framebuffer engine.
// No dependencies; imported by the front end, the back end and the top level.
`default_nettype none

package ofb_pkg;

   // Widest column address and column height the parameters allow.
   localparam int XW_MAX  = 8;
   localparam int COL_MAX = 64;

   // Work kinds handed from the front end to the back end.
   localparam logic [1:0] CMD_DRAW    = 2'd0;
   localparam logic [1:0] CMD_CLEAR   = 2'd1;
   localparam logic [1:0] CMD_REFRESH = 2'd2;

   typedef struct packed {
      logic [1:0]        kind;
      logic              on;
      logic [XW_MAX-1:0] x_lo;
      logic [XW_MAX-1:0] x_hi;
      logic [COL_MAX-1:0] mask;   // bit HEIGHT-1-y selects pixel row y
      logic [2:0]        page;
   } cmd_type;

endpackage

`default_nettype wire

### src/ofb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module ofb_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]        wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### src/ofb_front.sv
// Front end: accepts requests, orders and clips the corners, builds the row mask,
// and drops requests that touch nothing. Depends on ofb_pkg.
`default_nettype none

module ofb_front #(
   parameter int WIDTH  = 128,
   parameter int HEIGHT = 64
) (
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   input  wire logic [1:0]      operation,
   input  wire logic [6:0]      x_first,
   input  wire logic [5:0]      y_first,
   input  wire logic [6:0]      x_second,
   input  wire logic [5:0]      y_second,
   input  wire logic            pixel_on,
   input  wire logic [2:0]      page_index,
   input  wire logic            q_full,
   output logic                 q_push,
   output ofb_pkg::cmd_type     q_cmd
);
   import ofb_pkg::*;

   localparam int PAGES    = HEIGHT / 8;
   localparam int COL_BITS = 8 * PAGES;

   localparam logic [1:0] OP_POINT   = 2'd0;
   localparam logic [1:0] OP_FILL    = 2'd1;
   localparam logic [1:0] OP_CLEAR   = 2'd2;
   localparam logic [1:0] OP_REFRESH = 2'd3;

   localparam logic [8:0] WIDTH_V = 9'(WIDTH);
   localparam logic [3:0] PAGES_V = 4'(PAGES);

   logic [6:0]         xb, x_lo, x_hi;
   logic [5:0]         yb, y_lo, y_hi;
   logic [COL_MAX-1:0] mask;
   logic               keep;

   // A point is a rectangle whose two corners coincide.
   assign xb   = (operation == OP_POINT) ? x_first : x_second;
   assign yb   = (operation == OP_POINT) ? y_first : y_second;
   assign x_lo = (x_first > xb) ? xb : x_first;
   assign x_hi = (x_first > xb) ? x_first : xb;
   assign y_lo = (y_first > yb) ? yb : y_first;
   assign y_hi = (y_first > yb) ? y_first : yb;

   always_comb begin
      int yv;
      mask = '0;
      for (int i = 0; i < COL_BITS; i++) begin
         yv      = COL_BITS - 1 - i;
         mask[i] = (yv >= int'(y_lo)) && (yv <= int'(y_hi));
      end
   end

   always_comb begin
      q_cmd      = '0;
      q_cmd.on   = pixel_on;
      q_cmd.mask = mask;
      q_cmd.page = page_index;
      q_cmd.x_lo = XW_MAX'(x_lo);
      q_cmd.x_hi = (9'(x_hi) < WIDTH_V) ? XW_MAX'(x_hi) : XW_MAX'(WIDTH - 1);
      keep       = 1'b0;
      case (operation)
         OP_POINT, OP_FILL: begin
            q_cmd.kind = CMD_DRAW;
            keep       = (9'(x_lo) < WIDTH_V) && (mask != '0);
         end
         OP_CLEAR: begin
            q_cmd.kind = CMD_CLEAR;
            keep       = 1'b1;
         end
         OP_REFRESH: begin
            q_cmd.kind = CMD_REFRESH;
            keep       = ({1'b0, page_index} < PAGES_V);
         end
         default: begin
            q_cmd.kind = CMD_CLEAR;
            keep       = 1'b0;
         end
      endcase
   end

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && req_tready && keep;

endmodule

`default_nettype wire

### src/ofb_queue.sv
// Short first-in first-out queue between the front end and the back end.
// No dependencies.
`default_nettype none

module ofb_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] din,
   output logic                   full,
   input  wire logic              pop,
   output logic [DATA_W-1:0]      dout,
   output logic                   empty
);

   localparam int PW = $clog2(DEPTH);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PW:0]       cnt_ff, cnt_in;

   assign full  = (cnt_ff == (PW+1)'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign dout  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

`default_nettype wire

### src/ofb_back.sv
// Back end: column-wide read-modify-write of the framebuffer and the page refresh
// sequencer with its output register. Depends on ofb_pkg and ofb_ram.
`default_nettype none

module ofb_back #(
   parameter int WIDTH  = 128,
   parameter int HEIGHT = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ofb_pkg::cmd_type q_cmd,
   input  wire logic             q_empty,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic                  rsp_cmd,
   output logic [3:0]            rsp_cnt,
   output logic [63:0]           rsp_word,
   output logic                  rsp_last
);
   import ofb_pkg::*;

   localparam int PAGES    = HEIGHT / 8;
   localparam int COL_BITS = 8 * PAGES;
   localparam int AW       = $clog2(WIDTH);
   localparam int CW       = AW + 1;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_DRAW_RD = 3'd1;
   localparam logic [2:0] ST_DRAW_WR = 3'd2;
   localparam logic [2:0] ST_REF_HDR = 3'd3;
   localparam logic [2:0] ST_REF_RD  = 3'd4;
   localparam logic [2:0] ST_REF_OUT = 3'd5;

   localparam logic [7:0] PAGE_CMD_BASE  = 8'hB0;
   localparam logic [7:0] COL_LOW_CMD    = 8'h00;
   localparam logic [7:0] COL_HIGH_CMD   = 8'h10;
   localparam logic [3:0] HDR_BYTES      = 4'd3;
   localparam logic [3:0] BYTES_PER_WORD = 4'd8;
   localparam logic [CW-1:0] COL_END     = CW'(WIDTH);

   logic [2:0]          state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [CW-1:0]       col_ff, col_in;
   logic [3:0]          iss_ff, iss_in, rcv_ff, rcv_in;
   logic                rvld_ff, rvld_in, vrd_ff, vrd_in;
   logic [63:0]         word_ff, word_in;
   logic [WIDTH-1:0]    valid_ff, valid_in;
   logic                rsp_vld_ff, rsp_vld_in;
   logic                rsp_cmd_ff, rsp_cmd_in, rsp_last_ff, rsp_last_in;
   logic [3:0]          rsp_cnt_ff, rsp_cnt_in;
   logic [63:0]         rsp_word_ff, rsp_word_in;

   logic                out_free, issue, col_ok;
   logic [AW-1:0]       col_idx;
   logic [COL_BITS-1:0] ram_rdata, base, wdata, mask;
   logic [7:0]          page_byte;

   assign out_free = !rsp_vld_ff || rsp_tready;
   assign col_idx  = col_ff[AW-1:0];
   assign col_ok   = (col_ff < COL_END);
   assign issue    = (state_ff == ST_REF_RD) && (iss_ff != BYTES_PER_WORD) && (col_ff != COL_END);
   assign q_pop    = (state_ff == ST_IDLE) && !q_empty;

   // A column never written since reset or the last clear reads as blank.
   assign base  = vrd_ff ? ram_rdata : '0;
   assign mask  = cmd_ff.mask[COL_BITS-1:0];
   assign wdata = cmd_ff.on ? (base | mask) : (base & ~mask);

   always_comb begin
      page_byte = '0;
      for (int j = 0; j < PAGES; j++) begin
         if (cmd_ff.page == 3'(j)) begin
            page_byte = ram_rdata[8*j +: 8];
         end
      end
      if (!vrd_ff) begin
         page_byte = '0;
      end
   end

   ofb_ram #(
      .DATA_W (COL_BITS),
      .DEPTH  (WIDTH)
   ) u_frame (
      .clock   (clock),
      .wr_en   (state_ff == ST_DRAW_WR),
      .wr_addr (col_idx),
      .wr_data (wdata),
      .rd_addr (col_idx),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      col_in      = col_ff;
      iss_in      = iss_ff;
      rcv_in      = rcv_ff;
      rvld_in     = issue;
      vrd_in      = col_ok ? valid_ff[col_idx] : 1'b0;
      word_in     = word_ff;
      valid_in    = valid_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_cmd_in  = rsp_cmd_ff;
      rsp_cnt_in  = rsp_cnt_ff;
      rsp_word_in = rsp_word_ff;
      rsp_last_in = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               cmd_in = q_cmd;
               case (q_cmd.kind)
                  CMD_DRAW: begin
                     col_in   = CW'(q_cmd.x_lo);
                     state_in = ST_DRAW_RD;
                  end
                  CMD_REFRESH: begin
                     state_in = ST_REF_HDR;
                  end
                  default: begin
                     valid_in = '0;
                  end
               endcase
            end
         end
         ST_DRAW_RD: begin
            state_in = ST_DRAW_WR;
         end
         ST_DRAW_WR: begin
            valid_in[col_idx] = 1'b1;
            if (col_ff == CW'(cmd_ff.x_hi)) begin
               state_in = ST_IDLE;
            end else begin
               col_in   = col_ff + 1'b1;
               state_in = ST_DRAW_RD;
            end
         end
         ST_REF_HDR: begin
            if (out_free) begin
               rsp_vld_in  = 1'b1;
               rsp_cmd_in  = 1'b1;
               rsp_cnt_in  = HDR_BYTES;
               rsp_word_in = 64'({COL_HIGH_CMD, COL_LOW_CMD, PAGE_CMD_BASE | {5'b0, cmd_ff.page}});
               rsp_last_in = 1'b0;
               col_in      = '0;
               iss_in      = '0;
               rcv_in      = '0;
               word_in     = '0;
               state_in    = ST_REF_RD;
            end
         end
         ST_REF_RD: begin
            // Reads are issued one column a cycle; each byte is captured in the cycle after its read.
            if (issue) begin
               col_in = col_ff + 1'b1;
               iss_in = iss_ff + 1'b1;
            end
            if (rvld_ff) begin
               word_in[{rcv_ff[2:0], 3'b000} +: 8] = page_byte;
               rcv_in = rcv_ff + 1'b1;
            end
            if (!issue && !rvld_ff) begin
               state_in = ST_REF_OUT;
            end
         end
         ST_REF_OUT: begin
            if (out_free) begin
               rsp_vld_in  = 1'b1;
               rsp_cmd_in  = 1'b0;
               rsp_cnt_in  = rcv_ff;
               rsp_word_in = word_ff;
               rsp_last_in = (col_ff == COL_END);
               iss_in      = '0;
               rcv_in      = '0;
               word_in     = '0;
               state_in    = (col_ff == COL_END) ? ST_IDLE : ST_REF_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         col_ff     <= '0;
         iss_ff     <= '0;
         rcv_ff     <= '0;
         rvld_ff    <= 1'b0;
         vrd_ff     <= 1'b0;
         valid_ff   <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         col_ff     <= col_in;
         iss_ff     <= iss_in;
         rcv_ff     <= rcv_in;
         rvld_ff    <= rvld_in;
         vrd_ff     <= vrd_in;
         valid_ff   <= valid_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      word_ff     <= word_in;
      rsp_cmd_ff  <= rsp_cmd_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_cmd    = rsp_cmd_ff;
   assign rsp_cnt    = rsp_cnt_ff;
   assign rsp_word   = rsp_word_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

`default_nettype wire

### src/mono_oled_framebuffer_engine.sv
// Top level of the monochrome OLED framebuffer engine: front end, queue, back end.
// The back end takes a request from the four-entry queue the cycle after acceptance at the
// earliest. Draw and fill read, then write, each touched column. A refresh leaves the queue
// and registers its command result; each data result then issues up to eight reads, takes in
// the last byte, hands over and registers its word. Reset empties the queue.
`default_nettype none
`include "assert_macros.svh"

module mono_oled_framebuffer_engine #(
   parameter int WIDTH  = 128,
   parameter int HEIGHT = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // x_first[6:0], y_first[12:7], x_second[19:13], y_second[25:20],
   // pixel_on[26], page_index[29:27], zero[31:30]
   input  wire logic [31:0] req_tdata,
   // operation[1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // byte_count[3:0], byte_word[67:4], zero[71:68]
   output logic [71:0]      rsp_tdata,
   // is_command[0]
   output logic             rsp_tuser,
   output logic             rsp_tlast
);
   import ofb_pkg::*;

   cmd_type      f_cmd, q_cmd;
   logic         q_push, q_pop, q_full, q_empty;
   logic [3:0]   rsp_cnt;
   logic [63:0]  rsp_word;
   logic         hdr_ok, cnt_ok;

   ofb_front #(
      .WIDTH  (WIDTH),
      .HEIGHT (HEIGHT)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .operation  (req_tuser),
      .x_first    (req_tdata[6:0]),
      .y_first    (req_tdata[12:7]),
      .x_second   (req_tdata[19:13]),
      .y_second   (req_tdata[25:20]),
      .pixel_on   (req_tdata[26]),
      .page_index (req_tdata[29:27]),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (f_cmd)
   );

   ofb_queue #(
      .DATA_W ($bits(cmd_type)),
      .DEPTH  (4)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (f_cmd),
      .full  (q_full),
      .pop   (q_pop),
      .dout  (q_cmd),
      .empty (q_empty)
   );

   ofb_back #(
      .WIDTH  (WIDTH),
      .HEIGHT (HEIGHT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_cmd      (q_cmd),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_cmd    (rsp_tuser),
      .rsp_cnt    (rsp_cnt),
      .rsp_word   (rsp_word),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {4'b0, rsp_word, rsp_cnt};

   assign hdr_ok = (rsp_cnt == 4'd3) && !rsp_tlast;
   assign cnt_ok = (rsp_cnt != 4'd0) && (rsp_cnt <= 4'd8);

   `AM_ASSERT(a_hdr_shape, clock, reset, rsp_tvalid && rsp_tuser |-> hdr_ok, "bad command result")
   `AM_ASSERT(a_cnt_range, clock, reset, rsp_tvalid |-> cnt_ok, "byte count out of range")
   `AM_FORBID(a_push_full, clock, reset, q_push && q_full, "queue written while full")
   `AM_FORBID(a_pop_empty, clock, reset, q_pop && q_empty, "queue read while empty")

endmodule

`default_nettype wire
